// ----- src/fcht_pkg.sv -----
// Shared types and constants of the frequency count table.
// No dependencies; imported by fcht_cell and frequency_count_hash_table_unit.
package fcht_pkg;

    // Pool size: one cell per pool entry.
    localparam int POOL_ENTRIES = 64;

    // Field widths fixed by the interface.
    localparam int KEY_W   = 32;
    localparam int COUNT_W = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

    // Lookup word that travels down the row of cells.
    typedef struct packed {
        logic               valid;    // stage holds a word
        logic               done;     // a cell already hit or claimed an entry
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
        logic               was_new;
    } fcht_tok_t;

endpackage

// ----- src/fcht_cell.sv -----
// One pool entry of the frequency count table plus one stage of the lookup row.
// Depends on fcht_pkg.
module fcht_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  fcht_pkg::fcht_tok_t tok_i,
    output fcht_pkg::fcht_tok_t tok_o
);
    import fcht_pkg::*;

    fcht_tok_t          tok_reg;
    fcht_tok_t          tok_next;
    logic               entry_valid_reg;
    logic               entry_valid_next;
    logic [KEY_W-1:0]   entry_key_reg;
    logic [KEY_W-1:0]   entry_key_next;
    logic [COUNT_W-1:0] entry_count_reg;
    logic [COUNT_W-1:0] entry_count_next;
    logic               live;
    logic               hit;
    logic               claim;

    // Match the passing word against this entry, or claim the entry if free.
    // Entries fill in order, so the first free cell is the next pool entry.
    always_comb begin
        tok_next         = tok_i;
        entry_valid_next = entry_valid_reg;
        entry_key_next   = entry_key_reg;
        entry_count_next = entry_count_reg;
        live             = tok_i.valid && !tok_i.done;
        hit              = live && entry_valid_reg && (entry_key_reg == tok_i.key);
        claim            = live && !entry_valid_reg;
        if (hit) begin
            // saturate at the top of the count range
            if (entry_count_reg != COUNT_MAX) begin
                entry_count_next = entry_count_reg + COUNT_ONE;
            end
            tok_next.done    = 1'b1;
            tok_next.count   = entry_count_next;
            tok_next.was_new = 1'b0;
        end else if (claim) begin
            entry_valid_next = 1'b1;
            entry_key_next   = tok_i.key;
            entry_count_next = COUNT_ONE;
            tok_next.done    = 1'b1;
            tok_next.count   = COUNT_ONE;
            tok_next.was_new = 1'b1;
        end
    end

    // Control state: stage word and entry valid bit.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg         <= '0;
            entry_valid_reg <= 1'b0;
        end else if (advance) begin
            tok_reg         <= tok_next;
            entry_valid_reg <= entry_valid_next;
        end
    end

    // Entry payload: undefined until claimed.
    always_ff @(posedge aclk) begin
        if (advance) begin
            entry_key_reg   <= entry_key_next;
            entry_count_reg <= entry_count_next;
        end
    end

    assign tok_o = tok_reg;

`ifndef ASSERT_OFF
    // A claimed entry is never released.
    a_entry_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        entry_valid_reg |=> entry_valid_reg)
        else $error("fcht_cell: entry valid bit dropped");

    // Nothing moves while the row is stalled.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(entry_valid_reg) && $stable(tok_reg.valid)
                     && $stable(tok_reg.done))
        else $error("fcht_cell: state changed during stall");

    // A resolved word never reports a zero count.
    a_done_count: assert property (@(posedge aclk) disable iff (!aresetn)
        tok_reg.valid && tok_reg.done |-> tok_reg.count != '0)
        else $error("fcht_cell: resolved word with zero count");

    // A freshly stored key starts at one.
    a_new_one: assert property (@(posedge aclk) disable iff (!aresetn)
        tok_reg.valid && tok_reg.done && tok_reg.was_new |-> tok_reg.count == COUNT_ONE)
        else $error("fcht_cell: new entry count not one");
`endif

endmodule

// ----- src/frequency_count_hash_table_unit.sv -----
// A word passes the stage register of every pool-entry cell from input accept to output valid,
// one cell per cycle while the row advances. Throughput: one word per cycle while the output
// is not stalled; words move down the row of pool-entry cells together. A stalled output
// freezes the whole row, so the input is stalled along with it. Reset (aresetn low, synchronous):
// all entries empty, row and output empty. Top level: row of fcht_cell instances; depends on fcht_pkg.
module frequency_count_hash_table_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [fcht_pkg::KEY_W-1:0] s_key,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [fcht_pkg::COUNT_W-1:0] m_count,
    output logic                         m_was_new,
    output logic                         m_table_full
);
    import fcht_pkg::*;

    // tok[i] feeds cell i; tok[POOL_ENTRIES] is the last stage, which is the output.
    fcht_tok_t tok [POOL_ENTRIES+1];
    fcht_tok_t head_tok;
    logic      advance;

    // Move the row whenever the last stage is empty or being taken.
    assign advance = !tok[POOL_ENTRIES].valid || m_ready;
    assign s_ready = advance;

    // Inject the new word, or a bubble, at the head of the row.
    always_comb begin
        head_tok       = '0;
        head_tok.valid = s_valid;
        head_tok.key   = s_key;
    end

    assign tok[0] = head_tok;

    // Row of pool entries; every key lives in at most one cell.
    for (genvar i = 0; i < POOL_ENTRIES; i++) begin : g_cell
        fcht_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .advance (advance),
            .tok_i   (tok[i]),
            .tok_o   (tok[i+1])
        );
    end

    // A word that no cell resolved found every entry taken: its key is not stored; output it flagged.
    assign m_valid      = tok[POOL_ENTRIES].valid;
    assign m_count      = tok[POOL_ENTRIES].done ? tok[POOL_ENTRIES].count : '0;
    assign m_was_new    = tok[POOL_ENTRIES].done ? tok[POOL_ENTRIES].was_new : 1'b1;
    assign m_table_full = !tok[POOL_ENTRIES].done;

endmodule

// ----- sim/frequency_count_hash_table_unit_tb.sv -----
// Self-checking testbench for frequency_count_hash_table_unit: counts keys against a
// chained-table predictor, with random idling on both channels.
// Depends on fcht_pkg and the frequency_count_hash_table_unit RTL.
module frequency_count_hash_table_unit_tb;
    import fcht_pkg::*;

    localparam int HASH_BUCKETS = 8;
    localparam int NO_ENTRY     = POOL_ENTRIES;
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_WORDS  = 135;
    localparam int SAT_HITS     = 40;
    localparam int REPORT_CAP   = 100;
    localparam int DRAIN_CYCLES = 2 * POOL_ENTRIES + 16;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               was_new;
        logic               table_full;
    } tally_t;

    // Chained table mirror plus the queue of tallies still owed by the block.
    class key_tally_table;
        int unsigned        head [HASH_BUCKETS];
        logic [KEY_W-1:0]   entry_key [POOL_ENTRIES];
        logic [COUNT_W-1:0] entry_count [POOL_ENTRIES];
        int unsigned        entry_link [POOL_ENTRIES];
        int unsigned        used;
        tally_t             expected_tallies [$];
        int                 errors;

        function new();
            foreach (head[i]) head[i] = NO_ENTRY;
            used   = 0;
            errors = 0;
        endfunction

        // Walk the bucket chain, then bump, insert or drop.
        function tally_t tally_key(logic [KEY_W-1:0] k);
            int          ks;
            int          b;
            int unsigned e;
            int unsigned steps;
            int          hit;
            tally_t      t;
            ks = k;
            b  = ks % HASH_BUCKETS;
            if (b < 0) b += HASH_BUCKETS;
            hit   = -1;
            e     = head[b];
            steps = 0;
            while (hit < 0 && e < used && e < NO_ENTRY && steps < POOL_ENTRIES) begin
                if (entry_key[e] == k) begin
                    hit = e;
                end else begin
                    e = entry_link[e];
                    steps++;
                end
            end
            if (hit >= 0) begin
                if (entry_count[hit] != COUNT_MAX) entry_count[hit] = entry_count[hit] + 1'b1;
                t.count      = entry_count[hit];
                t.was_new    = 1'b0;
                t.table_full = 1'b0;
            end else if (used < POOL_ENTRIES) begin
                entry_key[used]   = k;
                entry_count[used] = COUNT_ONE;
                entry_link[used]  = head[b];
                head[b]           = used;
                used++;
                t.count      = COUNT_ONE;
                t.was_new    = 1'b1;
                t.table_full = 1'b0;
            end else begin
                t.count      = '0;
                t.was_new    = 1'b1;
                t.table_full = 1'b1;
            end
            return t;
        endfunction

        function void note_key(logic [KEY_W-1:0] k);
            expected_tallies.push_back(tally_key(k));
        endfunction

        task report_mismatch(string msg);
            if (errors < REPORT_CAP) $display("mismatch: %s", msg);
            errors++;
        endtask

        // Compare one result word with the oldest owed tally.
        task check_word(logic [COUNT_W-1:0] count, logic was_new, logic table_full);
            tally_t t;
            if (expected_tallies.size() == 0) begin
                report_mismatch($sformatf("result word with nothing owed, count %0d", count));
            end else begin
                t = expected_tallies.pop_front();
                if (count !== t.count)
                    report_mismatch($sformatf("count %0d, want %0d", count, t.count));
                if (was_new !== t.was_new)
                    report_mismatch($sformatf("was_new %0b, want %0b", was_new, t.was_new));
                if (table_full !== t.table_full)
                    report_mismatch($sformatf("table_full %0b, want %0b",
                                              table_full, t.table_full));
            end
        endtask
    endclass

    logic                      aclk    = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic signed [KEY_W-1:0]   s_key   = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [COUNT_W-1:0]        m_count;
    logic                      m_was_new;
    logic                      m_table_full;

    int                        send_idle_pct = 0;
    int                        stall_pct     = 0;
    int                        idle_cycles   = 0;
    logic [KEY_W-1:0]          sent_keys [$];
    key_tally_table            sb;

    frequency_count_hash_table_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_key        (s_key),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_count      (m_count),
        .m_was_new    (m_was_new),
        .m_table_full (m_table_full)
    );

    always #5 aclk = ~aclk;

    // Stall the result channel at random.
    always @(posedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= stall_pct);
    end

    // Check every accepted result word.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_word(m_count, m_was_new, m_table_full);
    end

    // Abort when nothing moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Offer one key, with a random gap first, and hold it until accepted.
    task automatic send_key(input logic [KEY_W-1:0] k);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_key   <= k;
        do @(posedge aclk); while (!s_ready);
        sb.note_key(k);
        sent_keys.push_back(k);
    endtask

    // Hold the sender until every owed word has come back.
    task automatic wait_drained();
        do @(posedge aclk); while (sb.expected_tallies.size() != 0);
    endtask

    // Mostly repeat seen keys; otherwise a wide, small or same-bucket fresh key.
    function automatic logic [KEY_W-1:0] pick_key();
        int v;
        if (sent_keys.size() > 0 && $urandom_range(99) < 65)
            return sent_keys[$urandom_range(sent_keys.size() - 1)];
        case ($urandom_range(3))
            0, 1: return $urandom;
            2: begin
                v = $urandom_range(40);
                return v - 20;
            end
            default: begin
                v = $urandom_range(1, 50);
                return sent_keys[$urandom_range(sent_keys.size() - 1)] + v * HASH_BUCKETS;
            end
        endcase
    endfunction

    logic [KEY_W-1:0] directed_keys [16] = '{
        32'h0000_0000, 32'h0000_0008, 32'hFFFF_FFF8, 32'h0000_0010,
        32'h0000_0008, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0007,
        32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFD, 32'h0000_0005,
        32'hFFFF_FFFD, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF
    };

    initial begin
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Shared buckets, negative keys, extreme keys, hits deep in a chain.
        foreach (directed_keys[i]) send_key(directed_keys[i]);

        // Hit one key back to back for a long run.
        repeat (SAT_HITS) send_key(32'h00A5_5A5A);
        s_valid <= 1'b0;
        wait_drained();

        // Random keys under each idling mix; pause for a full drain after each.
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 48; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 48; end
                default: begin send_idle_pct = 9; stall_pct = 9; end
            endcase
            repeat (PHASE_WORDS) send_key(pick_key());
            s_valid <= 1'b0;
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_tallies.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
